### design/clnw_pkg.sv
// shared types, constants and helpers for the character lcd nibble writer
// no dependencies; imported by every module of the block
package clnw_pkg;

    // default characters per display line
    localparam int DEF_LINE_CHARS = 16;

    // byte queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // command codes carried in tuser
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_DATA   = 3'd1;
    localparam logic [2:0] CMD_BYTE   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_MOVE   = 3'd4;
    localparam logic [2:0] CMD_NUMBER = 3'd5;

    // controller command bytes
    localparam logic [7:0] LCD_LINE1      = 8'h80;
    localparam logic [7:0] LCD_LINE2      = 8'hC0;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0F;
    localparam logic [7:0] LCD_WAKE_8BIT  = 8'h33;
    localparam logic [7:0] LCD_WAKE_4BIT  = 8'h32;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // addressing of rows two, three and four
    localparam logic [7:0] ROW3_BASE = 8'h14;
    localparam logic [7:0] ROW4_BASE = 8'h54;
    localparam logic [7:0] ROW2_BASE = 8'h40;

    localparam logic [13:0] NUM_MAX = 14'd9999;

    // one byte waiting for the nibble serialiser
    typedef struct packed {
        logic [7:0] byte_val;
        logic       rs;
        logic       last;
    } t_entry;

    // power-up sequence, written as byte pairs of nibbles
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = LCD_WAKE_8BIT;
            3'd1:    b = LCD_WAKE_4BIT;
            3'd2:    b = LCD_FUNC_4BIT;
            3'd3:    b = LCD_DISP_OFF;
            3'd4:    b = LCD_CLEAR;
            default: b = LCD_DISP_ON;
        endcase
        return b;
    endfunction

    // one shift-and-add-three step of binary to bcd conversion
    function automatic logic [15:0] dd_step(input logic [15:0] bcd, input logic b);
        logic [15:0] adj;
        adj = bcd;
        for (int d = 0; d < 4; d++) begin
            if (adj[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[14:0], b};
    endfunction

endpackage

### design/char_lcd_nibble_writer_top.sv
// top level of the character lcd nibble writer
// depends on clnw_pkg, clnw_front, clnw_queue and clnw_back
//
// Turns commands for a two-line character display on a 4-bit bus into
// nibbles, one per cycle on the output stream while tready is high, high
// nibble first, with tuser as the register select and tlast on the final
// nibble of a command. Every byte goes out as two nibbles: init gives 12
// nibbles, a data byte 2 to 4, a command byte, clear or move 2 (a move to
// an unmapped position gives nothing), a number 8 to 10. The nibble
// serialiser sets the rate; the front end queues up to four bytes ahead
// and runs the binary to decimal conversion of a number while earlier
// bytes drain, and it takes the next command in the cycle it queues the
// current one's last byte.
module char_lcd_nibble_writer_top
    import clnw_pkg::*;
#(
    parameter int LINE_CHARS = DEF_LINE_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value[7:0], number[21:8], row[23:22], column[27:24]
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // nibble[3:0]
    output logic        m_axis_tuser,  // reg_sel
    output logic        m_axis_tlast
);

    logic   q_push;
    logic   q_ready;
    t_entry q_in;
    logic   q_pop;
    logic   q_valid;
    t_entry q_out;
    logic [3:0] nibble;

    // command front end
    clnw_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_value   (s_axis_tdata[7:0]),
        .i_number  (s_axis_tdata[21:8]),
        .i_row     (s_axis_tdata[23:22]),
        .i_column  (s_axis_tdata[27:24]),
        .o_push    (q_push),
        .o_entry   (q_in),
        .i_q_ready (q_ready)
    );

    // byte queue
    clnw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_valid (q_valid)
    );

    // nibble serialiser
    clnw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_nibble  (nibble),
        .o_rs      (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, nibble};

endmodule

### design/clnw_queue.sv
// short byte queue parting the command front end from the nibble back end
// depends on clnw_pkg for the entry type and depth
module clnw_queue
    import clnw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_ready,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_valid
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/clnw_front.sv
// command front end: accepts commands, tracks the cursor and queues bytes
// depends on clnw_pkg for codes, constants and the bcd step
module clnw_front
    import clnw_pkg::*;
#(
    parameter int LINE_CHARS = DEF_LINE_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_value,
    input  logic [13:0] i_number,
    input  logic [1:0]  i_row,
    input  logic [3:0]  i_column,
    output logic        o_push,
    output t_entry      o_entry,
    input  logic        i_q_ready
);

    localparam logic [7:0] L1 = 8'(LINE_CHARS);
    localparam logic [7:0] L2 = 8'(2 * LINE_CHARS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_CMD  = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_CONV = 3'd4;
    localparam logic [2:0] ST_DATA = 3'd5;

    localparam logic PH_BYTE = 1'b0;
    localparam logic PH_POST = 1'b1;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_cursor, n_cursor;
    logic [7:0]  r_value, n_value;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_bcd, n_bcd;
    logic [13:0] r_bin, n_bin;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_left, n_left;
    logic        r_num, n_num;
    logic        r_ph, n_ph;
    logic        r_pre, n_pre;

    logic        push_acc;
    logic        fin;
    logic        accept;
    logic        mv_has;
    logic [7:0]  mv_addr;
    logic [7:0]  cur_byte;
    logic [7:0]  cur_inc;
    logic        wrap;
    logic [15:0] bcd_half;
    logic [7:0]  move_pos;

    // cursor address for a move command
    always_comb begin
        mv_has  = 1'b1;
        mv_addr = r_cursor;
        if (r_cursor < L1) begin
            mv_addr = r_cursor;
        end else if (r_cursor < L2) begin
            mv_addr = r_cursor - L1 + ROW2_BASE;
        end else if (r_cursor >= 8'd41 && r_cursor < 8'd60) begin
            mv_addr = r_cursor - 8'd40 + ROW3_BASE;
        end else if (r_cursor >= 8'd20 && r_cursor < 8'd40) begin
            mv_addr = r_cursor + ROW4_BASE;
        end else begin
            mv_has = 1'b0;
        end
    end

    assign cur_byte = r_num ? {ASCII_DIGIT_HI, r_bcd[15:12]} : r_value;
    assign cur_inc  = r_cursor + 8'd1;
    assign wrap     = (cur_inc == L2);
    assign bcd_half = dd_step(r_bcd, r_bin[13]);
    assign move_pos = ({6'd0, i_row} * L1) + {4'd0, i_column};

    // byte offered to the queue
    always_comb begin
        o_push  = 1'b0;
        o_entry = '{byte_val: cur_byte, rs: 1'b0, last: 1'b0};
        case (r_state)
            ST_INIT: begin
                o_push  = 1'b1;
                o_entry = '{byte_val: init_byte(r_step), rs: 1'b0,
                            last: (r_step == 3'd5)};
            end
            ST_CMD: begin
                o_push  = 1'b1;
                o_entry = '{byte_val: r_value, rs: 1'b0, last: 1'b1};
            end
            ST_MOVE: begin
                o_push  = mv_has;
                o_entry = '{byte_val: LCD_LINE1 | mv_addr, rs: 1'b0, last: 1'b1};
            end
            ST_DATA: begin
                o_push = 1'b1;
                if (r_ph == PH_POST) begin
                    o_entry = '{byte_val: LCD_LINE1, rs: 1'b0, last: (r_left == 3'd1)};
                end else if (r_cursor == L1 && !r_pre) begin
                    o_entry = '{byte_val: LCD_LINE2, rs: 1'b0, last: 1'b0};
                end else begin
                    o_entry = '{byte_val: cur_byte, rs: 1'b1,
                                last: (r_left == 3'd1) && !wrap};
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    assign push_acc = o_push && i_q_ready;
    assign o_ready  = (r_state == ST_IDLE) || fin;
    assign accept   = i_valid && o_ready;

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_value  = r_value;
        n_step   = r_step;
        n_bcd    = r_bcd;
        n_bin    = r_bin;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_num    = r_num;
        n_ph     = r_ph;
        n_pre    = r_pre;
        fin      = 1'b0;

        case (r_state)
            ST_INIT: begin
                if (push_acc) begin
                    n_step = r_step + 3'd1;
                    fin    = (r_step == 3'd5);
                end
            end
            ST_CMD: begin
                fin = push_acc;
            end
            ST_MOVE: begin
                fin = !mv_has || push_acc;
            end
            ST_CONV: begin
                n_bcd = dd_step(bcd_half, r_bin[12]);
                n_bin = {r_bin[11:0], 2'b00};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    n_state = ST_DATA;
                    n_left  = 3'd4;
                    n_ph    = PH_BYTE;
                    n_pre   = 1'b0;
                end
            end
            ST_DATA: begin
                if (push_acc) begin
                    if (r_ph == PH_POST) begin
                        n_ph  = PH_BYTE;
                        n_pre = 1'b0;
                        n_bcd = {r_bcd[11:0], 4'd0};
                        n_left = r_left - 3'd1;
                        fin   = (r_left == 3'd1);
                    end else if (r_cursor == L1 && !r_pre) begin
                        n_pre = 1'b1;
                    end else if (wrap) begin
                        n_cursor = '0;
                        n_ph     = PH_POST;
                    end else begin
                        n_cursor = cur_inc;
                        n_pre    = 1'b0;
                        n_bcd    = {r_bcd[11:0], 4'd0};
                        n_left   = r_left - 3'd1;
                        fin      = (r_left == 3'd1);
                    end
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase

        if (fin) begin
            n_state = ST_IDLE;
        end

        // a new command takes over in the cycle the last one finishes
        if (accept) begin
            case (i_cmd)
                CMD_INIT: begin
                    n_state  = ST_INIT;
                    n_cursor = '0;
                    n_step   = '0;
                end
                CMD_DATA: begin
                    n_state = ST_DATA;
                    n_value = i_value;
                    n_num   = 1'b0;
                    n_left  = 3'd1;
                    n_ph    = PH_BYTE;
                    n_pre   = 1'b0;
                end
                CMD_BYTE: begin
                    n_state = ST_CMD;
                    n_value = i_value;
                end
                CMD_CLEAR: begin
                    n_state  = ST_CMD;
                    n_value  = LCD_CLEAR;
                    n_cursor = '0;
                end
                CMD_MOVE: begin
                    n_state  = ST_MOVE;
                    n_cursor = move_pos;
                end
                CMD_NUMBER: begin
                    n_state = ST_CONV;
                    n_bin   = (i_number > NUM_MAX) ? NUM_MAX : i_number;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_num   = 1'b1;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_step  <= n_step;
        r_bcd   <= n_bcd;
        r_bin   <= n_bin;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_num   <= n_num;
        r_ph    <= n_ph;
        r_pre   <= n_pre;
    end

endmodule

### design/clnw_back.sv
// nibble back end: takes queued bytes and sends them high nibble first
// depends on clnw_pkg for the entry type
module clnw_back
    import clnw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_q_data,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_nibble,
    output logic       o_rs,
    output logic       o_last
);

    t_entry r_ent;
    logic   r_valid;
    logic   r_half;
    logic   out_acc;

    assign out_acc = r_valid && i_ready;
    assign o_pop   = i_q_valid && (!r_valid || (out_acc && r_half));

    assign o_valid  = r_valid;
    assign o_nibble = r_half ? r_ent.byte_val[3:0] : r_ent.byte_val[7:4];
    assign o_rs     = r_ent.rs;
    assign o_last   = r_half && r_ent.last;

    // held byte
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_data;
        end
    end

    // nibble select and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_half  <= 1'b0;
        end else if (out_acc) begin
            if (!r_half) begin
                r_half <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### verif/tb_top.sv
// self-checking testbench for the character lcd nibble writer
// depends on clnw_pkg and char_lcd_nibble_writer_top; predicts every nibble run
`timescale 1ns / 1ps

module tb_top;
    import clnw_pkg::*;

    localparam int          LINE_CHARS = DEF_LINE_CHARS;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  CMD_SPARE6 = 3'd6;
    localparam logic [2:0]  CMD_SPARE7 = 3'd7;

    // one command for the display front end
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  value;
        logic [13:0] number;
        logic [1:0]  row;
        logic [3:0]  column;
        logic        drain;
    } t_lcd_cmd;

    // one nibble on the lcd bus
    typedef struct packed {
        logic [3:0] nibble;
        logic       reg_sel;
        logic       last;
    } t_lcd_nib;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // value[7:0], number[21:8], row[23:22], column[27:24]
    logic [2:0]  s_axis_tuser = '0;  // cmd[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // nibble[3:0]
    logic        m_axis_tuser;       // reg_sel
    logic        m_axis_tlast;

    t_lcd_cmd    cmd_backlog[$];
    t_lcd_nib    nibbles_due[$];
    t_lcd_nib    run_buf[$];
    logic [7:0]  cursor_pos = '0;
    t_lcd_cmd    cmd_on_bus;
    int          cmds_sent = 0;
    int          nibs_seen = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    logic        hold_off = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;

    char_lcd_nibble_writer_top #(.LINE_CHARS(LINE_CHARS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // nibble run builder, capped at twelve nibbles per command
    function automatic void lcd_nib(input logic [3:0] nib, input logic rs);
        t_lcd_nib e;
        if (run_buf.size() < 12) begin
            e.nibble  = nib;
            e.reg_sel = rs;
            e.last    = 1'b0;
            run_buf.push_back(e);
        end
    endfunction

    function automatic void lcd_cmd_byte(input logic [7:0] b);
        lcd_nib(b[7:4], 1'b0);
        lcd_nib(b[3:0], 1'b0);
    endfunction

    // data byte with the line wrap around it
    function automatic void lcd_char(input logic [7:0] b);
        if (cursor_pos == 8'(LINE_CHARS)) begin
            lcd_cmd_byte(LCD_LINE2);
        end
        lcd_nib(b[7:4], 1'b1);
        lcd_nib(b[3:0], 1'b1);
        cursor_pos = cursor_pos + 8'd1;
        if (cursor_pos == 8'(2 * LINE_CHARS)) begin
            lcd_cmd_byte(LCD_LINE1);
            cursor_pos = '0;
        end
    endfunction

    // expected nibbles for one accepted command
    function automatic void lcd_predict(input t_lcd_cmd c);
        int         p;
        int         n;
        t_lcd_nib   e;
        run_buf.delete();
        case (c.cmd)
            CMD_INIT: begin
                cursor_pos = '0;
                lcd_cmd_byte(LCD_WAKE_8BIT);
                lcd_cmd_byte(LCD_WAKE_4BIT);
                lcd_cmd_byte(LCD_FUNC_4BIT);
                lcd_cmd_byte(LCD_DISP_OFF);
                lcd_cmd_byte(LCD_CLEAR);
                lcd_cmd_byte(LCD_DISP_ON);
            end
            CMD_DATA: begin
                lcd_char(c.value);
            end
            CMD_BYTE: begin
                lcd_cmd_byte(c.value);
            end
            CMD_CLEAR: begin
                lcd_cmd_byte(LCD_CLEAR);
                cursor_pos = '0;
            end
            CMD_MOVE: begin
                p = (int'(c.row) * LINE_CHARS + int'(c.column)) & 8'hFF;
                cursor_pos = 8'(p);
                if (p < LINE_CHARS) begin
                    lcd_cmd_byte(LCD_LINE1 | 8'(p));
                end else if (p < 2 * LINE_CHARS) begin
                    lcd_cmd_byte(LCD_LINE1 | 8'(p % LINE_CHARS + int'(ROW2_BASE)));
                end else if (p >= 41 && p < 60) begin
                    lcd_cmd_byte(LCD_LINE1 | 8'(p % 40 + int'(ROW3_BASE)));
                end else if (p >= 20 && p < 40) begin
                    lcd_cmd_byte(LCD_LINE1 | 8'(p % 60 + int'(ROW4_BASE)));
                end
                // unmapped positions send nothing
            end
            CMD_NUMBER: begin
                n = (c.number > NUM_MAX) ? int'(NUM_MAX) : int'(c.number);
                lcd_char({ASCII_DIGIT_HI, 4'(n / 1000)});
                lcd_char({ASCII_DIGIT_HI, 4'((n % 1000) / 100)});
                lcd_char({ASCII_DIGIT_HI, 4'((n % 100) / 10)});
                lcd_char({ASCII_DIGIT_HI, 4'(n % 10)});
            end
            default: begin
                // spare codes are ignored
            end
        endcase
        for (int i = 0; i < run_buf.size(); i++) begin
            e = run_buf[i];
            e.last = (i == run_buf.size() - 1);
            nibbles_due.push_back(e);
        end
    endfunction

    function automatic t_lcd_cmd mk_cmd(input logic [2:0] cmd, input logic [7:0] value,
                                        input logic [13:0] number, input logic [1:0] row,
                                        input logic [3:0] column, input logic drain);
        t_lcd_cmd c;
        c.cmd    = cmd;
        c.value  = value;
        c.number = number;
        c.row    = row;
        c.column = column;
        c.drain  = drain;
        return c;
    endfunction

    // random command with noise in the unused fields
    function automatic t_lcd_cmd rand_cmd();
        t_lcd_cmd c;
        int       r;
        r = $urandom_range(0, 99);
        c = mk_cmd(CMD_DATA, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)),
                   2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0);
        if (r < 4)       c.cmd = CMD_INIT;
        else if (r < 42) c.cmd = CMD_DATA;
        else if (r < 56) c.cmd = CMD_NUMBER;
        else if (r < 72) c.cmd = CMD_MOVE;
        else if (r < 84) c.cmd = CMD_BYTE;
        else if (r < 92) c.cmd = CMD_CLEAR;
        else if (r < 96) c.cmd = CMD_SPARE6;
        else             c.cmd = CMD_SPARE7;
        if (c.cmd == CMD_NUMBER && $urandom_range(0, 99) < 85) begin
            c.number = 14'($urandom_range(0, 9999));
        end
        return c;
    endfunction

    // stimulus and end of run
    initial begin : stimulus
        t_lcd_cmd c;
        int       counted;
        int       burst;
        // directed part: field extremes, every command, unmapped moves, wraps
        cmd_backlog.push_back(mk_cmd(CMD_INIT,   8'h00, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_DATA,   8'h00, 14'd16383, 2'd3, 4'd15, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_DATA,   8'hFF, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_BYTE,   8'h00, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_BYTE,   8'hFF, 14'd16383, 2'd3, 4'd15, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_CLEAR,  8'h5A, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd1, 4'd15, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd2, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd2, 4'd8,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd2, 4'd9,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd3, 4'd11, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd3, 4'd12, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd3, 4'd15, 1'b1));
        cmd_backlog.push_back(mk_cmd(CMD_SPARE6, 8'hFF, 14'd9999,  2'd1, 4'd1,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_SPARE7, 8'h00, 14'd0,     2'd2, 4'd2,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_NUMBER, 8'h00, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_NUMBER, 8'h00, 14'd9999,  2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_NUMBER, 8'h00, 14'd16383, 2'd0, 4'd0,  1'b0));
        // data across the end of line one, then across the end of line two
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd0, 4'd14, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_NUMBER, 8'h00, 14'd1234,  2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_MOVE,   8'h00, 14'd0,     2'd1, 4'd14, 1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_DATA,   8'h41, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_DATA,   8'h42, 14'd0,     2'd0, 4'd0,  1'b0));
        cmd_backlog.push_back(mk_cmd(CMD_DATA,   8'h43, 14'd0,     2'd0, 4'd0,  1'b0));

        // random part: mostly cursor runs and text, spare codes as noise
        counted = 0;
        while (counted < 105) begin
            if ($urandom_range(0, 99) < 20) begin
                c = rand_cmd();
                c.cmd    = CMD_MOVE;
                c.row    = 2'($urandom_range(0, 1));
                c.column = 4'($urandom_range(10, 15));
                cmd_backlog.push_back(c);
                counted++;
                burst = $urandom_range(2, 7);
                for (int i = 0; i < burst; i++) begin
                    c = rand_cmd();
                    c.cmd = ($urandom_range(0, 3) == 0) ? CMD_NUMBER : CMD_DATA;
                    cmd_backlog.push_back(c);
                    counted++;
                end
            end else begin
                c = rand_cmd();
                if (c.cmd != CMD_SPARE6 && c.cmd != CMD_SPARE7) counted++;
                c.drain = (counted == 100);
                cmd_backlog.push_back(c);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (nibbles_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // command driver
    always @(posedge i_clk) begin : cmd_driver
        logic     busy;
        t_lcd_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = $urandom_range(0, 9);
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                lcd_predict(cmd_on_bus);
                cmds_sent <= cmds_sent + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain && nibbles_due.size() != 0)) begin
                    c = cmd_backlog.pop_front();
                    cmd_on_bus = c;
                    s_axis_tdata <= {4'b0000, c.column, c.row, c.number, c.value};
                    s_axis_tuser <= c.cmd;
                    busy = 1'b1;
                    // every fourth stretch of commands goes back to back
                    tx_gap = (((cmds_sent / 25) % 4) == 2) ? 0 : $urandom_range(0, 9);
                end
            end
            s_axis_tvalid <= busy;
        end
    end

    // long receiver hold-off once the run is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end else if (!hold_done && !hold_off && cmds_sent >= 60) begin
            hold_off <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_off) begin
            if (hold_cnt == 1) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_cnt <= hold_cnt - 1;
        end
    end

    // nibble monitor and checker
    always @(posedge i_clk) begin : nib_monitor
        t_lcd_nib got;
        t_lcd_nib want;
        logic     rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = $urandom_range(0, 9);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.nibble  = m_axis_tdata[3:0];
                got.reg_sel = m_axis_tuser;
                got.last    = m_axis_tlast;
                if (nibbles_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected nibble %h rs %b last %b",
                                 got.nibble, got.reg_sel, got.last);
                    end
                end else begin
                    want = nibbles_due.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("nibble %0d: expected %h rs %b last %b, got %h rs %b last %b",
                                     nibs_seen, want.nibble, want.reg_sel, want.last,
                                     got.nibble, got.reg_sel, got.last);
                        end
                    end
                end
                nibs_seen <= nibs_seen + 1;
                rx_gap = (((nibs_seen / 60) % 4) == 1) ? 0 : $urandom_range(0, 9);
            end
            if (hold_off) begin
                rdy = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
